// ===== rtl/core/plcv_pkg.sv =====
// Package for the PMBus linear / single precision converter.
// Holds the channel item types, action codes, pipeline stage types and constants.
// No dependencies.
`default_nettype none

package plcv_pkg;

   typedef enum logic [1:0] {
      ACT_L11_DEC = 2'd0,
      ACT_L11_ENC = 2'd1,
      ACT_L16_DEC = 2'd2,
      ACT_L16_ENC = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] operand;
   } req_type;

   typedef struct packed {
      logic [31:0] result;
      logic        range_error;
   } rsp_type;

   // classified operand, ahead of the alignment shift
   typedef struct packed {
      action_type         action;
      logic               sgn;
      logic               nan;
      logic               inf;
      logic               tiny;
      logic               big;
      logic [23:0]        mag;
      logic [4:0]         sh;
      logic signed [9:0]  ee;
   } stage2_type;

   // aligned operand, ahead of packing
   typedef struct packed {
      action_type         action;
      logic               sgn;
      logic               nan;
      logic               inf;
      logic               tiny;
      logic               big;
      logic [23:0]        t;
      logic               frac;
      logic [3:0]         lead;
      logic signed [9:0]  ee;
   } stage3_type;

   localparam logic [4:0]  L16_EXP_RESET = 5'd19;
   localparam logic [4:0]  L11_EXP_MAX   = 5'h0F;
   localparam logic [4:0]  L11_EXP_MIN   = 5'h10;
   localparam logic [10:0] L11_MANT_MAX  = 11'h3FF;
   localparam logic [10:0] L11_MANT_MIN  = 11'h400;
   localparam logic [15:0] L16_MANT_MAX  = 16'hFFFF;

endpackage

`default_nettype wire

// ===== rtl/core/pmbus_linear_float_converter.sv =====
// Top level of the PMBus Linear11/Linear16 to single precision converter.
// Depends on plcv_pkg for item types, action codes and stage types.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    req_data  (action, operand)
//   rsp       out        rsp_valid/rsp_ready    rsp_data  (result, range_error)
//   csr       in         csr_wr_en              csr_wr_data (Linear16 exponent)
//
// Four register stages: input, classify, align shift, pack. One item per cycle
// is sustained while rsp_ready stays high.
// Each stage holds when the one after it is full and stalled; nothing drops.
// Synchronous reset empties the pipeline and sets the exponent to -13.
`default_nettype none

module pmbus_linear_float_converter
   import plcv_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire req_type    req_data,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      rsp_type    rsp_data,
   input  wire logic       csr_wr_en,
   input  wire logic [4:0] csr_wr_data
);

   logic [4:0] exp_code_ff;
   logic       v1_ff, v2_ff, v3_ff, vo_ff;
   logic       en1, en2, en3, eno;
   req_type    s1_ff;
   stage2_type s2_ff, s2_in;
   stage3_type s3_ff, s3_in;
   rsp_type    out_ff, out_in;
   action_type act_o_ff;

   // exponent register
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_code_ff <= L16_EXP_RESET;
      end else if (csr_wr_en) begin
         exp_code_ff <= csr_wr_data;
      end
   end

   // advance a stage when its successor is empty or moving
   assign eno = !vo_ff || rsp_ready;
   assign en3 = !v3_ff || eno;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (eno) vo_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) s1_ff <= req_data;
      if (en2) s2_ff <= s2_in;
      if (en3) s3_ff <= s3_in;
      if (eno) begin
         out_ff   <= out_in;
         act_o_ff <= s3_ff.action;
      end
   end

   // classify: split the operand and work out exponent and shift
   always_comb begin
      logic [7:0]        ex;
      logic [22:0]       fr;
      logic              pow2;
      logic signed [9:0] n16;
      logic signed [9:0] ec;
      logic signed [9:0] sfull;
      logic signed [9:0] ef;
      logic signed [9:0] r;
      logic signed [9:0] rs;
      logic [11:0]       mag12;
      ex    = s1_ff.operand[30:23];
      fr    = s1_ff.operand[22:0];
      pow2  = (fr == 23'd0);
      n16   = {{5{exp_code_ff[4]}}, exp_code_ff};
      s2_in = '0;
      s2_in.action = action_type'(s1_ff.action);
      s2_in.sgn  = s1_ff.operand[31];
      s2_in.nan  = (ex == 8'hFF) && !pow2;
      s2_in.inf  = (ex == 8'hFF) && pow2;
      s2_in.tiny = (ex == 8'd0);
      s2_in.mag  = {(ex != 8'd0), fr};
      ec    = $signed({2'b00, ex}) - 10'sd136 - $signed({9'd0, s1_ff.operand[31] & pow2});
      sfull = '0;
      ef    = '0;
      r     = '0;
      rs    = '0;
      mag12 = '0;
      unique case (action_type'(s1_ff.action))
         ACT_L11_ENC: begin
            if (ec < -10'sd16) ec = -10'sd16;
            sfull = ec - $signed({2'b00, ex}) + 10'sd150;
            s2_in.sh = (sfull > 10'sd31) ? 5'd31 : sfull[4:0];
            s2_in.ee = ec;
         end
         ACT_L16_ENC: begin
            ef = (ex == 8'd0) ? -10'sd149 : $signed({2'b00, ex}) - 10'sd150;
            r  = ef - n16;
            s2_in.big = (r >= 10'sd0);
            rs = -r;
            s2_in.sh = (s2_in.big || rs > 10'sd31) ? 5'd31 : rs[4:0];
         end
         ACT_L11_DEC: begin
            mag12 = s1_ff.operand[10] ? 12'd0 - {1'b1, s1_ff.operand[10:0]}
                                      : {1'b0, s1_ff.operand[10:0]};
            s2_in.sgn = s1_ff.operand[10];
            s2_in.mag = {12'd0, mag12};
            s2_in.sh  = 5'd0;
            s2_in.ee  = {{5{s1_ff.operand[15]}}, s1_ff.operand[15:11]};
         end
         ACT_L16_DEC: begin
            s2_in.sgn = 1'b0;
            s2_in.mag = {8'd0, s1_ff.operand[15:0]};
            s2_in.sh  = 5'd0;
            s2_in.ee  = n16;
         end
         default: s2_in.sh = 5'd0;
      endcase
   end

   // align: shift out fraction bits and find the leading one
   always_comb begin
      s3_in.action = s2_ff.action;
      s3_in.sgn    = s2_ff.sgn;
      s3_in.nan    = s2_ff.nan;
      s3_in.inf    = s2_ff.inf;
      s3_in.tiny   = s2_ff.tiny;
      s3_in.big    = s2_ff.big;
      s3_in.ee     = s2_ff.ee;
      s3_in.t      = s2_ff.mag >> s2_ff.sh;
      s3_in.frac   = |(s2_ff.mag & ~(24'hFFFFFF << s2_ff.sh));
      s3_in.lead   = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (s2_ff.mag[i]) s3_in.lead = 4'(i);
      end
   end

   // pack the result word
   always_comb begin
      logic signed [9:0] bexp;
      logic [23:0]       norm;
      logic              bump;
      logic signed [9:0] e11;
      logic [10:0]       m11;
      bexp = s3_ff.ee + $signed({6'd0, s3_ff.lead}) + 10'sd127;
      norm = {s3_ff.t[15:0], 8'd0} << (4'd15 - s3_ff.lead);
      bump = !s3_ff.sgn && (s3_ff.t[23:11] == 13'd0) && (s3_ff.t[10:0] == L11_MANT_MAX)
             && s3_ff.frac;
      e11  = s3_ff.ee + $signed({9'd0, bump});
      m11  = bump ? 11'd511 : s3_ff.t[10:0];
      m11  = s3_ff.sgn ? 11'd0 - m11 : m11;
      out_in = '0;
      unique case (s3_ff.action)
         ACT_L11_DEC, ACT_L16_DEC: begin
            if (s3_ff.t[15:0] != 16'd0) begin
               out_in.result = {s3_ff.sgn, bexp[7:0], norm[22:0]};
            end
         end
         ACT_L11_ENC: begin
            if (s3_ff.nan) begin
               out_in.range_error = 1'b1;
            end else if (s3_ff.inf || (!s3_ff.tiny && e11 > 10'sd15)) begin
               out_in.range_error = 1'b1;
               out_in.result = {16'd0, L11_EXP_MAX,
                                s3_ff.sgn ? L11_MANT_MIN : L11_MANT_MAX};
            end else if (s3_ff.tiny) begin
               out_in.result = {16'd0, L11_EXP_MIN, 11'd0};
            end else begin
               out_in.result = {16'd0, e11[4:0], m11};
            end
         end
         ACT_L16_ENC: begin
            if (s3_ff.nan) begin
               out_in.range_error = 1'b1;
            end else if (s3_ff.sgn) begin
               out_in.range_error = s3_ff.inf || s3_ff.big || (s3_ff.t != 24'd0);
            end else if (s3_ff.inf || s3_ff.big || (s3_ff.t[23:16] != 8'd0)) begin
               out_in.range_error = 1'b1;
               out_in.result = {16'd0, L16_MANT_MAX};
            end else begin
               out_in.result = {16'd0, s3_ff.t[15:0]};
            end
         end
         default: out_in = '0;
      endcase
   end

   assign rsp_valid = vo_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_empty_after_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("pipeline not empty after reset");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");
   a_decode_no_error: assert property (@(posedge clock) disable iff (reset)
      vo_ff && (act_o_ff == ACT_L11_DEC || act_o_ff == ACT_L16_DEC) |-> !out_ff.range_error)
      else $error("range error on a decode");
   a_encode_upper_zero: assert property (@(posedge clock) disable iff (reset)
      vo_ff && (act_o_ff == ACT_L11_ENC || act_o_ff == ACT_L16_ENC)
      |-> out_ff.result[31:16] == 16'd0)
      else $error("encode result upper half not zero");
`endif

endmodule

`default_nettype wire
